FILE: design/scd_pkg.sv
// Package for the STUN datagram classifier.
// Holds the protocol constants, the result kind codes and the result record type.
// The parser, the result register and the top level use it; it depends on nothing.
package scd_pkg;

  // STUN header constants
  localparam logic [31:0] MAGIC_COOKIE       = 32'h2112_A442;
  localparam logic [15:0] HEADER_BYTES       = 16'd20;
  localparam logic [15:0] TYPE_BIND_REQUEST  = 16'h0001;
  localparam logic [15:0] TYPE_BIND_RESPONSE = 16'h0101;
  localparam logic [15:0] ATTR_XOR_MAPPED    = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4        = 8'h01;
  localparam logic [15:0] MIN_MAPPED_LEN     = 16'd8;
  localparam logic [15:0] OFFSET_MAX         = 16'hFFFF;

  // First-byte tags of application datagrams
  localparam logic [7:0] TAG_PING   = 8'hFF;
  localparam logic [7:0] TAG_TEXT   = 8'h01;
  localparam logic [7:0] TAG_AUDIO  = 8'h02;
  localparam logic [7:0] TAG_SCREEN = 8'h03;
  localparam logic [7:0] TAG_FILE   = 8'h04;

  // Classification codes
  typedef enum logic [3:0] {
    KIND_PING      = 4'd0,
    KIND_TEXT      = 4'd1,
    KIND_AUDIO     = 4'd2,
    KIND_SCREEN    = 4'd3,
    KIND_FILE      = 4'd4,
    KIND_UNKNOWN   = 4'd5,
    KIND_BIND_REQ  = 4'd6,
    KIND_BIND_RESP = 4'd7,
    KIND_OTHER     = 4'd8
  } kind_e;

  // One classification result
  typedef struct packed {
    kind_e       kind;
    logic        mapped_found;
    logic [15:0] mapped_port;
    logic [31:0] mapped_addr;
    logic [63:0] tid_high;
    logic [31:0] tid_low;
    logic [15:0] payload_len;
  } result_t;

endpackage

FILE: design/scd_in_reg.sv
// Input register of the STUN datagram classifier.
// Captures one byte item per cycle and holds a last byte while the result side is full.
// Depends on nothing but its ports.
module scd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       hold_i,       // result register full and not taken
  output logic       step_o,       // held item goes to the parser this cycle
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  // a last byte must wait for room in the result register
  assign step_o     = valid_q && !(last_q && hold_i);
  assign in_ready_o = !valid_q || step_o;
  assign byte_o     = byte_q;
  assign last_o     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (step_o) begin
      valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

endmodule

FILE: design/scd_parser.sv
// Per-datagram parser of the STUN datagram classifier.
// Keeps the header captures and the attribute walk, and forms the result on the last byte.
// Depends on scd_pkg.
module scd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output scd_pkg::result_t result_o
);

  logic [15:0] offset_q, offset_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] msg_type_q, msg_type_d;
  logic [15:0] hdr_len_q, hdr_len_d;
  logic [31:0] cookie_q, cookie_d;
  logic [63:0] tid_high_q, tid_high_d;
  logic [31:0] tid_low_q, tid_low_d;
  logic [15:0] attr_start_q, attr_start_d;
  logic [15:0] attr_type_q, attr_type_d;
  logic [15:0] attr_len_q, attr_len_d;
  logic        found_q, found_d;
  logic [15:0] port_q, port_d;
  logic [31:0] addr_q, addr_d;
  logic        walk_done_q, walk_done_d;

  logic [16:0] rel;          // byte index relative to attribute start
  logic        at_attr;
  logic [15:0] rel_off;
  logic [15:0] new_len;
  logic [17:0] adv_len;
  logic [17:0] next_start;
  logic [16:0] dgram_len;
  logic [17:0] attr_end;
  logic        is_stun;

  assign rel     = {1'b0, offset_q} - {1'b0, attr_start_q};
  assign at_attr = !rel[16];
  assign rel_off = rel[15:0];
  assign new_len = {attr_len_q[15:8], byte_i};

  // length used when skipping an attribute: completed length at its last
  // header byte, the stored length at the family byte
  always_comb begin
    if (rel_off == 16'd3) begin
      adv_len = ({2'b00, new_len} + 18'd3) & ~18'd3;
    end else begin
      adv_len = ({2'b00, attr_len_q} + 18'd3) & ~18'd3;
    end
    next_start = {2'b00, attr_start_q} + 18'd4 + adv_len;
  end

  // next-state logic for one byte
  always_comb begin
    offset_d     = offset_q;
    first_d      = first_q;
    msg_type_d   = msg_type_q;
    hdr_len_d    = hdr_len_q;
    cookie_d     = cookie_q;
    tid_high_d   = tid_high_q;
    tid_low_d    = tid_low_q;
    attr_start_d = attr_start_q;
    attr_type_d  = attr_type_q;
    attr_len_d   = attr_len_q;
    found_d      = found_q;
    port_d       = port_q;
    addr_d       = addr_q;
    walk_done_d  = walk_done_q;

    if (offset_q != scd_pkg::OFFSET_MAX) begin
      offset_d = offset_q + 16'd1;
      if (offset_q == 16'd0) begin
        first_d    = byte_i;
        msg_type_d = {byte_i, 8'h00};
      end else if (offset_q == 16'd1) begin
        msg_type_d = {msg_type_q[15:8], byte_i};
      end else if (offset_q == 16'd2) begin
        hdr_len_d = {byte_i, 8'h00};
      end else if (offset_q == 16'd3) begin
        hdr_len_d = {hdr_len_q[15:8], byte_i};
      end else if (offset_q < 16'd8) begin
        cookie_d = {cookie_q[23:0], byte_i};
      end else if (offset_q < 16'd16) begin
        tid_high_d = {tid_high_q[55:0], byte_i};
      end else if (offset_q < scd_pkg::HEADER_BYTES) begin
        tid_low_d = {tid_low_q[23:0], byte_i};
      end else if (!walk_done_q && at_attr) begin
        // attribute walk
        if (found_q) begin
          if (rel_off == 16'd6 || rel_off == 16'd7) begin
            port_d = {port_q[7:0], byte_i};
          end else if (rel_off >= 16'd8 && rel_off <= 16'd11) begin
            addr_d = {addr_q[23:0], byte_i};
          end
        end else begin
          case (rel_off)
            16'd0: begin
              if ({1'b0, attr_start_q} + 17'd4 >
                  {1'b0, scd_pkg::HEADER_BYTES} + {1'b0, hdr_len_q}) begin
                walk_done_d = 1'b1;
              end else begin
                attr_type_d = {byte_i, 8'h00};
              end
            end
            16'd1: begin
              attr_type_d = {attr_type_q[15:8], byte_i};
            end
            16'd2: begin
              attr_len_d = {byte_i, 8'h00};
            end
            16'd3: begin
              attr_len_d = new_len;
              if (attr_type_q != scd_pkg::ATTR_XOR_MAPPED ||
                  new_len < scd_pkg::MIN_MAPPED_LEN) begin
                if (next_start[17:16] != 2'b00) begin
                  walk_done_d = 1'b1;
                end else begin
                  attr_start_d = next_start[15:0];
                end
              end
            end
            16'd5: begin
              if (byte_i == scd_pkg::FAMILY_IPV4) begin
                found_d = 1'b1;
              end else if (next_start[17:16] != 2'b00) begin
                walk_done_d = 1'b1;
              end else begin
                attr_start_d = next_start[15:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // classification from the state after this byte
  assign dgram_len = {1'b0, offset_q} + 17'd1;
  assign attr_end  = {2'b00, attr_start_d} + 18'd4 + {2'b00, attr_len_d};
  assign is_stun   = (offset_q >= (scd_pkg::HEADER_BYTES - 16'd1)) &&
                     (cookie_d == scd_pkg::MAGIC_COOKIE);

  always_comb begin
    result_o = '0;
    if (is_stun) begin
      result_o.tid_high = tid_high_d;
      result_o.tid_low  = tid_low_d;
      if (msg_type_d == scd_pkg::TYPE_BIND_REQUEST) begin
        result_o.kind = scd_pkg::KIND_BIND_REQ;
      end else if (msg_type_d == scd_pkg::TYPE_BIND_RESPONSE) begin
        result_o.kind = scd_pkg::KIND_BIND_RESP;
        if (found_d && !walk_done_d && attr_end <= {1'b0, dgram_len}) begin
          result_o.mapped_found = 1'b1;
          result_o.mapped_port  = port_d ^ scd_pkg::MAGIC_COOKIE[31:16];
          result_o.mapped_addr  = addr_d ^ scd_pkg::MAGIC_COOKIE;
        end
      end else begin
        result_o.kind = scd_pkg::KIND_OTHER;
      end
    end else begin
      case (first_d)
        scd_pkg::TAG_PING:   result_o.kind = scd_pkg::KIND_PING;
        scd_pkg::TAG_TEXT:   result_o.kind = scd_pkg::KIND_TEXT;
        scd_pkg::TAG_AUDIO:  result_o.kind = scd_pkg::KIND_AUDIO;
        scd_pkg::TAG_SCREEN: result_o.kind = scd_pkg::KIND_SCREEN;
        scd_pkg::TAG_FILE:   result_o.kind = scd_pkg::KIND_FILE;
        default:             result_o.kind = scd_pkg::KIND_UNKNOWN;
      endcase
      result_o.payload_len = offset_q;
    end
  end

  // state registers, back to reset values after each datagram
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      first_q      <= '0;
      msg_type_q   <= '0;
      hdr_len_q    <= '0;
      cookie_q     <= '0;
      tid_high_q   <= '0;
      tid_low_q    <= '0;
      attr_start_q <= scd_pkg::HEADER_BYTES;
      attr_type_q  <= '0;
      attr_len_q   <= '0;
      found_q      <= 1'b0;
      port_q       <= '0;
      addr_q       <= '0;
      walk_done_q  <= 1'b0;
    end else if (step_i && last_i) begin
      offset_q     <= '0;
      first_q      <= '0;
      msg_type_q   <= '0;
      hdr_len_q    <= '0;
      cookie_q     <= '0;
      tid_high_q   <= '0;
      tid_low_q    <= '0;
      attr_start_q <= scd_pkg::HEADER_BYTES;
      attr_type_q  <= '0;
      attr_len_q   <= '0;
      found_q      <= 1'b0;
      port_q       <= '0;
      addr_q       <= '0;
      walk_done_q  <= 1'b0;
    end else if (step_i) begin
      offset_q     <= offset_d;
      first_q      <= first_d;
      msg_type_q   <= msg_type_d;
      hdr_len_q    <= hdr_len_d;
      cookie_q     <= cookie_d;
      tid_high_q   <= tid_high_d;
      tid_low_q    <= tid_low_d;
      attr_start_q <= attr_start_d;
      attr_type_q  <= attr_type_d;
      attr_len_q   <= attr_len_d;
      found_q      <= found_d;
      port_q       <= port_d;
      addr_q       <= addr_d;
      walk_done_q  <= walk_done_d;
    end
  end

endmodule

FILE: design/scd_out_reg.sv
// Result register of the STUN datagram classifier.
// Holds one classification item until the downstream side takes it.
// Depends on scd_pkg.
module scd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  scd_pkg::result_t result_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             hold_o,
  output scd_pkg::result_t result_o
);

  logic             valid_q;
  scd_pkg::result_t result_q;

  assign out_valid_o = valid_q;
  assign hold_o      = valid_q && !out_ready_i;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: design/stun_datagram_classifier.sv
// STUN datagram classifier: takes one datagram byte per item and gives one
// classification item on the byte marked last. An input register feeds the
// header capture and attribute walk logic, which writes the result register,
// so a new byte is accepted every cycle while no last byte is held, and the
// result is registered when its last byte leaves the input register. A last
// byte waits in the input register only while the result register still holds
// an item that has not been taken. Depends on scd_pkg, scd_in_reg, scd_parser
// and scd_out_reg.
module stun_datagram_classifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] mapped_port, [47:16] mapped_addr, [111:48] tid_high,
  // [143:112] tid_low, [159:144] payload_len
  output logic [159:0] m_axis_tdata,
  output logic [4:0]   m_axis_tuser    // [3:0] kind, [4] mapped_found
);

  logic             hold;
  logic             step;
  logic [7:0]       in_byte;
  logic             in_last;
  scd_pkg::result_t next_result;
  scd_pkg::result_t result;

  scd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .hold_i     (hold),
    .step_o     (step),
    .byte_o     (in_byte),
    .last_o     (in_last)
  );

  scd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte),
    .last_i   (in_last),
    .result_o (next_result)
  );

  scd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && in_last),
    .result_i    (next_result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hold_o      (hold),
    .result_o    (result)
  );

  // pack the result item onto the stream
  assign m_axis_tdata = {result.payload_len, result.tid_low, result.tid_high,
                         result.mapped_addr, result.mapped_port};
  assign m_axis_tuser = {result.mapped_found, result.kind};

endmodule
